// ===== hdl/pcen_pkg.sv =====
// pcen_pkg: shared widths, latencies, register indexes, types and helper functions
// for the band normaliser; no dependencies, imported by every module of the block but pcen_ram

package pcen_pkg;

    // band store
    localparam int NUM_BANDS = 64;
    localparam int BAND_AW   = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;

    // field widths
    localparam int DW  = 40;        // Q16.24 energies
    localparam int CW  = 17;        // Q1.16 coefficients, 65536 is one
    localparam int IW  = 6;         // band index
    localparam int LXW = DW + 1;    // log2 operand, sum of two Q16.24 values
    localparam int LPW = 6;         // leading-one position
    localparam int MW  = 31;        // Q1.30 mantissa
    localparam int FRAC_STEPS = 16;
    localparam int LW  = 23;        // signed Q.16 log2 value
    localparam int PW  = CW + 1 + LW;
    localparam int TW  = PW - 16;
    localparam int QW  = 26;        // signed Q.16 exponent
    localparam int IEW = QW - 16;

    // pipeline depth of the log and exp units
    localparam int LOG_LAT = FRAC_STEPS + 2;
    localparam int EXP_LAT = FRAC_STEPS + 1;

    // front to back queue
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [DW-1:0] MAX_Q24   = '1;
    localparam logic [DW-1:0] UNITY_Q24 = 40'h00_0100_0000;
    localparam logic [CW-1:0] COEF_ONE  = 17'h1_0000;
    localparam logic [MW-1:0] ONE_Q30   = 31'h4000_0000;

    // configuration register indexes
    localparam int CFG_IW = 3;
    localparam logic [CFG_IW-1:0] REG_SMOOTH_COEF   = 3'd0;
    localparam logic [CFG_IW-1:0] REG_GAIN_EXPONENT = 3'd1;
    localparam logic [CFG_IW-1:0] REG_BIAS_OFFSET   = 3'd2;
    localparam logic [CFG_IW-1:0] REG_ROOT_EXPONENT = 3'd3;
    localparam logic [CFG_IW-1:0] REG_STABILIZER    = 3'd4;
    localparam logic [CFG_IW-1:0] REG_ENERGY_FLOOR  = 3'd5;

    // coefficients already limited to one
    typedef struct packed {
        logic [CW-1:0] smooth;
        logic [CW-1:0] alpha;
        logic [CW-1:0] root;
        logic [DW-1:0] bias;
        logic [DW-1:0] stab;
        logic [DW-1:0] floor_lvl;
    } cfg_t;

    // item handed from front to back
    typedef struct packed {
        logic [DW-1:0] energy;
        logic [DW-1:0] smooth;
        logic [IW-1:0] band;
        logic          in_range;
    } fe_item_t;

    // per-item control carried along the back pipeline
    typedef struct packed {
        logic [IW-1:0] band;
        logic          in_range;
        logic          e_zero;
        logic          x_zero;
    } sb_t;

    function automatic logic [CW-1:0] clamp_q16(input logic [CW-1:0] v);
        return (v > COEF_ONE) ? COEF_ONE : v;
    endfunction

    // product divided by 65536, truncated toward zero
    function automatic logic signed [TW-1:0] div_q16(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] adj;
        adj = p[PW-1] ? (p + PW'(65535)) : p;
        return TW'(adj >>> 16);
    endfunction

    // bitwise integer square root, used for constants only
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] rem;
        logic [63:0] bit_v;
        res   = '0;
        rem   = v;
        bit_v = 64'h4000_0000_0000_0000;
        for (int n = 0; n < 32; n++) begin
            if (bit_v > rem) bit_v = bit_v >> 2;
        end
        for (int n = 0; n < 32; n++) begin
            if (bit_v != '0) begin
                if (rem >= res + bit_v) begin
                    rem = rem - (res + bit_v);
                    res = (res >> 1) + bit_v;
                end else begin
                    res = res >> 1;
                end
                bit_v = bit_v >> 2;
            end
        end
        return res;
    endfunction

    // 2^(2^-k) in Q1.30 by repeated square roots of two
    function automatic logic [MW-1:0] root_q30(input int k);
        logic [63:0] rt;
        rt = isqrt64(64'h2000_0000_0000_0000);
        for (int j = 1; j < k; j++) begin
            rt = isqrt64(rt << 30);
        end
        return rt[MW-1:0];
    endfunction

endpackage

// ===== hdl/pcen_ram.sv =====
// pcen_ram: generic single write port, single read port ram with registered read
// no package dependency

module pcen_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/pcen_front.sv =====
// pcen_front: input stage, energy floor and per-band smoother update
// depends on pcen_pkg and pcen_ram

module pcen_front import pcen_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  cfg_t          cfg,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [DW-1:0] s_band_energy,
    input  logic [IW-1:0] s_band_index,
    output logic          push,
    output fe_item_t      push_item,
    input  logic          q_full
);

    localparam int PRW = DW + 1 + CW + 1;

    logic               accept;
    logic [DW-1:0]      e_floor;
    logic [BAND_AW-1:0] raddr;
    logic [DW-1:0]      rdata;

    logic               f1_valid_reg;
    logic [DW-1:0]      f1_energy_reg;
    logic [IW-1:0]      f1_band_reg;
    logic               f1_range_reg;
    logic [BAND_AW-1:0] f1_addr_reg;

    logic [(2**BAND_AW)-1:0] vbits_reg;
    logic               byp_valid_reg;
    logic [BAND_AW-1:0] byp_addr_reg;
    logic [DW-1:0]      byp_data_reg;

    logic [DW-1:0]        old_m;
    logic signed [DW:0]   diff;
    logic signed [PRW-1:0] prod;
    logic signed [PRW-1:0] rnd;
    logic signed [PRW-1:0] total;
    logic [DW-1:0]        m_next;
    logic                 wr_en;

    assign accept  = s_valid && s_ready;
    assign e_floor = (s_band_energy < cfg.floor_lvl) ? cfg.floor_lvl : s_band_energy;
    assign raddr   = BAND_AW'(s_band_index);
    assign push    = f1_valid_reg && !q_full;
    assign s_ready = !f1_valid_reg || !q_full;
    assign wr_en   = push && f1_range_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg <= 1'b0;
        end else if (accept) begin
            f1_valid_reg <= 1'b1;
        end else if (push) begin
            f1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            f1_energy_reg <= e_floor;
            f1_band_reg   <= s_band_index;
            f1_range_reg  <= int'(s_band_index) < NUM_BANDS;
            f1_addr_reg   <= raddr;
        end
    end

    pcen_ram #(
        .WIDTH (DW),
        .DEPTH (NUM_BANDS)
    ) u_smooth_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (f1_addr_reg),
        .wdata (m_next),
        .re    (accept),
        .raddr (raddr),
        .rdata (rdata)
    );

    // last write bypasses the ram read taken on the same edge
    always_comb begin
        priority if (byp_valid_reg && (byp_addr_reg == f1_addr_reg)) begin
            old_m = byp_data_reg;
        end else if (vbits_reg[f1_addr_reg]) begin
            old_m = rdata;
        end else begin
            old_m = '0;
        end
    end

    // (1-s)M + sE rewritten as M + s(E-M), same rounding
    always_comb begin
        diff   = $signed({1'b0, f1_energy_reg}) - $signed({1'b0, old_m});
        prod   = $signed({1'b0, cfg.smooth}) * diff;
        rnd    = prod + PRW'(32768);
        total  = (rnd >>> 16) + $signed(PRW'(old_m));
        m_next = total[DW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vbits_reg     <= '0;
            byp_valid_reg <= 1'b0;
        end else if (wr_en) begin
            vbits_reg[f1_addr_reg] <= 1'b1;
            byp_valid_reg          <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            byp_addr_reg <= f1_addr_reg;
            byp_data_reg <= m_next;
        end
    end

    assign push_item = '{energy:   f1_energy_reg,
                         smooth:   m_next,
                         band:     f1_band_reg,
                         in_range: f1_range_reg};

endmodule

// ===== hdl/pcen_queue.sv =====
// pcen_queue: short fifo in flip-flops between front and back
// depends on pcen_pkg

module pcen_queue import pcen_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  fe_item_t push_item,
    output logic     full,
    input  logic     pop,
    output fe_item_t head,
    output logic     head_valid
);

    fe_item_t         entry_reg [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg;
    logic [QAW-1:0]   rd_ptr_reg;
    logic [QAW:0]     count_reg;
    logic [QAW:0]     count_next;

    assign full       = (count_reg == (QAW+1)'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];

    always_comb begin
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== hdl/pcen_log2.sv =====
// pcen_log2: pipelined log2 by leading-one search and repeated squaring
// depends on pcen_pkg

module pcen_log2 import pcen_pkg::*; (
    input  logic                 aclk,
    input  logic                 en,
    input  logic [LXW-1:0]       x,
    output logic signed [LW-1:0] lg
);

    logic [LPW-1:0] lead;
    logic [LXW-1:0] xa_reg;
    logic [LPW-1:0] pa_reg;
    logic [LXW-1:0] norm;

    logic [MW-1:0]         m_reg  [0:FRAC_STEPS];
    logic [FRAC_STEPS-1:0] fr_reg [0:FRAC_STEPS];
    logic [LPW-1:0]        p_reg  [0:FRAC_STEPS];

    always_comb begin
        lead = '0;
        for (int k = 0; k < LXW; k++) begin
            if (x[k]) lead = LPW'(k);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            xa_reg <= x;
            pa_reg <= lead;
        end
    end

    // leading one moved to the top, Q1.30 mantissa
    assign norm = xa_reg << (LPW'(LXW - 1) - pa_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            m_reg[0]  <= norm[LXW-1 -: MW];
            fr_reg[0] <= '0;
            p_reg[0]  <= pa_reg;
        end
    end

    for (genvar j = 1; j <= FRAC_STEPS; j++) begin : g_sq
        logic [2*MW-1:0] sq;
        logic [MW:0]     sqh;
        assign sq  = m_reg[j-1] * m_reg[j-1];
        assign sqh = sq[2*MW-1:MW-1];
        always_ff @(posedge aclk) begin
            if (en) begin
                m_reg[j]  <= sqh[MW] ? sqh[MW:1] : sqh[MW-1:0];
                fr_reg[j] <= {fr_reg[j-1][FRAC_STEPS-2:0], sqh[MW]};
                p_reg[j]  <= p_reg[j-1];
            end
        end
    end

    logic signed [LW-17:0] ipart;
    assign ipart = (LW-16)'(p_reg[FRAC_STEPS]) - (LW-16)'(24);
    assign lg    = {ipart, fr_reg[FRAC_STEPS]};

endmodule

// ===== hdl/pcen_exp2.sv =====
// pcen_exp2: pipelined exp2 as a product of constant roots, then a saturating shift
// depends on pcen_pkg

module pcen_exp2 import pcen_pkg::*; (
    input  logic                 aclk,
    input  logic                 en,
    input  logic signed [QW-1:0] q,
    output logic [DW-1:0]        y
);

    logic [MW-1:0]          m_reg [1:FRAC_STEPS];
    logic signed [IEW-1:0]  i_reg [1:FRAC_STEPS];
    logic [15:0]            f_reg [1:FRAC_STEPS];
    logic [DW-1:0]          y_reg;
    logic [DW-1:0]          y_next;

    for (genvar k = 1; k <= FRAC_STEPS; k++) begin : g_mul
        localparam logic [MW-1:0] ROOT_K = root_q30(k);
        logic [MW-1:0]         m_prev;
        logic signed [IEW-1:0] i_prev;
        logic [15:0]           f_prev;
        logic [2*MW-1:0]       prod;
        if (k == 1) begin : g_first
            assign m_prev = ONE_Q30;
            assign i_prev = q[QW-1:16];
            assign f_prev = q[15:0];
        end else begin : g_rest
            assign m_prev = m_reg[k-1];
            assign i_prev = i_reg[k-1];
            assign f_prev = f_reg[k-1];
        end
        assign prod = m_prev * ROOT_K;
        always_ff @(posedge aclk) begin
            if (en) begin
                m_reg[k] <= f_prev[FRAC_STEPS-k] ? prod[2*MW-2:MW-1] : m_prev;
                i_reg[k] <= i_prev;
                f_reg[k] <= f_prev;
            end
        end
    end

    logic signed [IEW-1:0] i_f;
    logic [MW-1:0]         m_f;
    logic signed [IEW-1:0] dl;
    logic signed [IEW-1:0] dr;

    assign i_f = i_reg[FRAC_STEPS];
    assign m_f = m_reg[FRAC_STEPS];
    assign dl  = i_f - IEW'(6);
    assign dr  = IEW'(6) - i_f;

    // integer part sets the final scale, beyond range saturates or flushes
    always_comb begin
        priority if (i_f > IEW'(15)) begin
            y_next = MAX_Q24;
        end else if (i_f < -IEW'(40)) begin
            y_next = '0;
        end else if (i_f >= IEW'(6)) begin
            y_next = DW'(m_f) << dl[3:0];
        end else begin
            y_next = DW'(m_f >> dr[5:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            y_reg <= y_next;
        end
    end

    assign y = y_reg;

endmodule

// ===== hdl/pcen_back.sv =====
// pcen_back: stalling pipeline for ratio, bias and root compression
// depends on pcen_pkg, pcen_log2 and pcen_exp2

module pcen_back import pcen_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  cfg_t          cfg,
    input  fe_item_t      head,
    input  logic          head_valid,
    output logic          pop,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [DW-1:0] m_pcen_value,
    output logic [IW-1:0] m_band_out
);

    // stage numbers of the key points
    localparam int P_Q     = LOG_LAT + 2;
    localparam int P_RATIO = P_Q + EXP_LAT;
    localparam int P_X     = P_RATIO + 1;
    localparam int P_QH    = P_X + LOG_LAT + 2;
    localparam int P_HI    = P_QH + EXP_LAT;
    localparam int NSTAGE  = P_HI + 1;

    logic adv;
    logic [NSTAGE-1:0] vld_reg;
    sb_t  sb_reg [NSTAGE];

    logic [LXW-1:0] d_sum;
    logic [LXW-1:0] d_in;
    logic signed [LW-1:0] lg_e;
    logic signed [LW-1:0] lg_d;
    logic signed [LW-1:0] lge_reg;
    logic signed [PW-1:0] prod_a_reg;
    logic signed [QW-1:0] q_reg;
    logic [DW-1:0]  ratio;
    logic [DW-1:0]  ratio_sel;
    logic [LXW-1:0] x_reg;
    logic           xz_next;
    logic signed [LW-1:0] lg_h;
    logic signed [LW-1:0] lg_l;
    logic signed [PW-1:0] prod_h_reg;
    logic signed [PW-1:0] prod_l_reg;
    logic signed [QW-1:0] qh_reg;
    logic signed [QW-1:0] ql_reg;
    logic [DW-1:0]  hi_e;
    logic [DW-1:0]  lo_e;
    logic [DW-1:0]  hi;
    logic [DW-1:0]  lo;
    logic [DW-1:0]  res;
    logic [DW-1:0]  pcen_reg;
    sb_t            sb_fin;

    assign adv = !vld_reg[NSTAGE-1] || m_ready;
    assign pop = adv && head_valid;

    // denominator eps + M, zero taken as one lsb
    assign d_sum = {1'b0, cfg.stab} + {1'b0, head.smooth};
    assign d_in  = (d_sum == '0) ? LXW'(1) : d_sum;

    pcen_log2 u_log_e (.aclk(aclk), .en(adv), .x({1'b0, head.energy}), .lg(lg_e));
    pcen_log2 u_log_d (.aclk(aclk), .en(adv), .x(d_in), .lg(lg_d));

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_a_reg <= $signed({1'b0, cfg.alpha}) * lg_d;
            lge_reg    <= lg_e;
            q_reg      <= QW'(lge_reg) - QW'(div_q16(prod_a_reg));
        end
    end

    pcen_exp2 u_exp_ratio (.aclk(aclk), .en(adv), .q(q_reg), .y(ratio));

    assign ratio_sel = sb_reg[P_RATIO-1].e_zero ? '0 : ratio;
    assign xz_next   = (ratio_sel == '0) && (cfg.bias == '0);

    always_ff @(posedge aclk) begin
        if (adv) begin
            x_reg <= {1'b0, ratio_sel} + {1'b0, cfg.bias};
        end
    end

    pcen_log2 u_log_h (.aclk(aclk), .en(adv), .x(x_reg), .lg(lg_h));
    pcen_log2 u_log_l (.aclk(aclk), .en(adv), .x({1'b0, cfg.bias}), .lg(lg_l));

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_h_reg <= $signed({1'b0, cfg.root}) * lg_h;
            prod_l_reg <= $signed({1'b0, cfg.root}) * lg_l;
            qh_reg     <= QW'(div_q16(prod_h_reg));
            ql_reg     <= QW'(div_q16(prod_l_reg));
        end
    end

    pcen_exp2 u_exp_h (.aclk(aclk), .en(adv), .q(qh_reg), .y(hi_e));
    pcen_exp2 u_exp_l (.aclk(aclk), .en(adv), .q(ql_reg), .y(lo_e));

    // zero exponent gives one, zero base gives zero
    assign sb_fin = sb_reg[P_HI-1];
    always_comb begin
        hi  = (cfg.root == '0) ? UNITY_Q24 : (sb_fin.x_zero ? '0 : hi_e);
        lo  = (cfg.root == '0) ? UNITY_Q24 : ((cfg.bias == '0) ? '0 : lo_e);
        res = (sb_fin.in_range && (hi > lo)) ? (hi - lo) : '0;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pcen_reg <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NSTAGE-2:0], head_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sb_reg[0] <= '{band:     head.band,
                           in_range: head.in_range,
                           e_zero:   (head.energy == '0),
                           x_zero:   1'b0};
        end
    end

    for (genvar k = 1; k < NSTAGE; k++) begin : g_sb
        if (k == P_X - 1) begin : g_xz
            // zero power base flag joins beside the bias adder
            always_ff @(posedge aclk) begin
                if (adv) begin
                    sb_reg[k] <= '{band:     sb_reg[k-1].band,
                                   in_range: sb_reg[k-1].in_range,
                                   e_zero:   sb_reg[k-1].e_zero,
                                   x_zero:   xz_next};
                end
            end
        end else begin : g_pass
            always_ff @(posedge aclk) begin
                if (adv) begin
                    sb_reg[k] <= sb_reg[k-1];
                end
            end
        end
    end

    assign m_valid      = vld_reg[NSTAGE-1];
    assign m_pcen_value = pcen_reg;
    assign m_band_out   = sb_reg[NSTAGE-1].band;

endmodule

// ===== hdl/pcen_band_normalizer_unit.sv =====
// pcen_band_normalizer_unit: top level of the per-band energy normaliser
// depends on pcen_pkg, pcen_front, pcen_queue and pcen_back
// throughput: one item per cycle while m_ready is high,
// set by the fully pipelined log2 and exp2 units
// a 4-entry queue lets the front keep taking items while a result waits
// reset: config registers take their defaults, smoother store reads as zero at once

module pcen_band_normalizer_unit import pcen_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    // configuration write channel
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [DW-1:0]     cfg_data,
    // input items
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [DW-1:0]     s_band_energy,
    input  logic [IW-1:0]     s_band_index,
    // results
    output logic              m_valid,
    input  logic              m_ready,
    output logic [DW-1:0]     m_pcen_value,
    output logic [IW-1:0]     m_band_out
);

    // configuration registers
    logic [CW-1:0] smooth_coef_reg;
    logic [CW-1:0] gain_exponent_reg;
    logic [DW-1:0] bias_offset_reg;
    logic [CW-1:0] root_exponent_reg;
    logic [DW-1:0] stabilizer_reg;
    logic [DW-1:0] energy_floor_reg;
    logic          cfg_wr;
    cfg_t          cfg;

    // front to queue to back
    logic     push;
    fe_item_t push_item;
    logic     q_full;
    logic     pop;
    fe_item_t head;
    logic     head_valid;

    // writes are always taken, an unknown index is ignored
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            smooth_coef_reg   <= 17'd1638;
            gain_exponent_reg <= 17'd64225;
            bias_offset_reg   <= 40'd33554432;
            root_exponent_reg <= 17'd32768;
            stabilizer_reg    <= 40'd17;
            energy_floor_reg  <= 40'd1;
        end else if (cfg_wr) begin
            unique case (cfg_index)
                REG_SMOOTH_COEF:   smooth_coef_reg   <= cfg_data[CW-1:0];
                REG_GAIN_EXPONENT: gain_exponent_reg <= cfg_data[CW-1:0];
                REG_BIAS_OFFSET:   bias_offset_reg   <= cfg_data;
                REG_ROOT_EXPONENT: root_exponent_reg <= cfg_data[CW-1:0];
                REG_STABILIZER:    stabilizer_reg    <= cfg_data;
                REG_ENERGY_FLOOR:  energy_floor_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // coefficients above one act as one
    assign cfg = '{smooth:    clamp_q16(smooth_coef_reg),
                   alpha:     clamp_q16(gain_exponent_reg),
                   root:      clamp_q16(root_exponent_reg),
                   bias:      bias_offset_reg,
                   stab:      stabilizer_reg,
                   floor_lvl: energy_floor_reg};

    // front: floor, smoother read-modify-write with a one-entry bypass
    pcen_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_band_energy (s_band_energy),
        .s_band_index  (s_band_index),
        .push          (push),
        .push_item     (push_item),
        .q_full        (q_full)
    );

    // decouples the front from output back-pressure
    pcen_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    // back: log, exponent products, exp, bias and root compression
    pcen_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .head         (head),
        .head_valid   (head_valid),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pcen_value (m_pcen_value),
        .m_band_out   (m_band_out)
    );

`ifndef SYNTHESIS
    // out of range bands never produce a non-zero value
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (int'(m_band_out) >= NUM_BANDS)) |-> (m_pcen_value == '0))
        else $error("non-zero result for band outside the smoother store");

    // after reset nothing is pending and the input side is open
    assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && s_ready))
        else $error("result pending or input blocked after reset");

    // the front only pushes when the queue has room
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_full |-> !push)
        else $error("queue overflow");
`endif

endmodule
